// ===== rtl/qrs_pkg.sv =====
`timescale 1ns / 1ps
package qrs_pkg;

    localparam int COEF_FRAC_BITS_DEF = 16;

    // Radicand, root and partial remainder widths of the square root chain.
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int SREM_W = 34;

    // Divisor magnitude width and numerator magnitude width of the divider chain.
    localparam int DVS_W = 33;
    localparam int NUM_W = 33;

    localparam logic [2:0] ST_TWO      = 3'd0;
    localparam logic [2:0] ST_DOUBLE   = 3'd1;
    localparam logic [2:0] ST_NONE     = 3'd2;
    localparam logic [2:0] ST_LINEAR   = 3'd3;
    localparam logic [2:0] ST_HIGH_DEG = 3'd4;
    localparam logic [2:0] ST_DIV_ZERO = 3'd5;
    localparam logic [2:0] ST_SAT      = 3'd6;

    // Classification of an equation, settled once the discriminant is known.
    localparam logic [2:0] MODE_HIGH   = 3'd0;
    localparam logic [2:0] MODE_LIN0   = 3'd1;
    localparam logic [2:0] MODE_LIN    = 3'd2;
    localparam logic [2:0] MODE_QDIV0  = 3'd3;
    localparam logic [2:0] MODE_QSAT   = 3'd4;
    localparam logic [2:0] MODE_QNONE  = 3'd5;
    localparam logic [2:0] MODE_QDBL   = 3'd6;
    localparam logic [2:0] MODE_QTWO   = 3'd7;

    typedef struct packed {
        logic signed [31:0] coef_sq;
        logic signed [31:0] coef_lin;
        logic signed [31:0] coef_const;
        logic        [3:0]  poly_degree;
    } request_t;

    typedef struct packed {
        logic signed [63:0] discriminant;
        logic signed [31:0] root_low;
        logic signed [31:0] root_high;
        logic        [2:0]  status;
    } result_t;

    typedef struct packed {
        logic        [2:0]  mode;
        logic signed [63:0] disc;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } root_side_t;

    typedef struct packed {
        logic        [2:0]  mode;
        logic signed [63:0] disc;
        logic               neg1;
        logic               neg2;
    } div_side_t;

endpackage

// ===== rtl/qrs_sqrt_cell.sv =====
`timescale 1ns / 1ps
module qrs_sqrt_cell
(
    input  logic                              clk,
    input  logic [qrs_pkg::SREM_W-1:0]        rem_i,
    input  logic [qrs_pkg::ROOT_W-1:0]        root_i,
    input  logic [qrs_pkg::RAD_W-1:0]         rad_i,
    output logic [qrs_pkg::SREM_W-1:0]        rem_o,
    output logic [qrs_pkg::ROOT_W-1:0]        root_o,
    output logic [qrs_pkg::RAD_W-1:0]         rad_o
);

    localparam int ACC_W = qrs_pkg::SREM_W + 2;

    logic [ACC_W-1:0]           acc;
    logic [ACC_W-1:0]           trial;
    logic [ACC_W-1:0]           diff;
    logic                       ge;
    logic [qrs_pkg::SREM_W-1:0] rem_next;
    logic [qrs_pkg::ROOT_W-1:0] root_next;
    logic [qrs_pkg::RAD_W-1:0]  rad_next;

    // One root bit per cell: bring down the next two radicand bits and try 4r+1.
    always_comb
    begin
        acc       = {rem_i, rad_i[qrs_pkg::RAD_W-1 -: 2]};
        trial     = {2'b00, root_i, 2'b01};
        diff      = acc - trial;
        ge        = (acc >= trial);
        rem_next  = ge ? diff[qrs_pkg::SREM_W-1:0] : acc[qrs_pkg::SREM_W-1:0];
        root_next = {root_i[qrs_pkg::ROOT_W-2:0], ge};
        rad_next  = {rad_i[qrs_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        rem_o  <= rem_next;
        root_o <= root_next;
        rad_o  <= rad_next;
    end

endmodule

// ===== rtl/qrs_div_cell.sv =====
`timescale 1ns / 1ps
module qrs_div_cell
#(
    parameter int NW = qrs_pkg::NUM_W + qrs_pkg::COEF_FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic [qrs_pkg::DVS_W-1:0]   rem_i,
    input  logic [NW-1:0]               dq_i,
    input  logic [qrs_pkg::DVS_W-1:0]   dvs_i,
    output logic [qrs_pkg::DVS_W-1:0]   rem_o,
    output logic [NW-1:0]               dq_o,
    output logic [qrs_pkg::DVS_W-1:0]   dvs_o
);

    logic [qrs_pkg::DVS_W:0]   trial;
    logic [qrs_pkg::DVS_W:0]   diff;
    logic                      ge;
    logic [qrs_pkg::DVS_W-1:0] rem_next;
    logic [NW-1:0]             dq_next;

    // The dividend leaves the top of dq as quotient bits enter at the bottom.
    always_comb
    begin
        trial    = {rem_i, dq_i[NW-1]};
        diff     = trial - {1'b0, dvs_i};
        ge       = (trial >= {1'b0, dvs_i});
        rem_next = ge ? diff[qrs_pkg::DVS_W-1:0] : trial[qrs_pkg::DVS_W-1:0];
        dq_next  = {dq_i[NW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        rem_o <= rem_next;
        dq_o  <= dq_next;
        dvs_o <= dvs_i;
    end

endmodule

// ===== rtl/quadratic_root_solver.sv =====
`timescale 1ns / 1ps
// Quadratic root solver, fully pipelined.
// An equation is taken as a transaction when start is high and busy is low;
// busy is held low, so one equation may be issued in every clock cycle.
// The request carries the three Q16.16 coefficients and the degree; the
// result carries the Q32.32 discriminant, the two Q16.16 roots and a status.
// Each result appears on the result port for exactly one cycle with done
// high, in the order the equations were issued.
// In order: a multiply stage forms b*b and a*c and a discriminant stage then
// forms the discriminant, a chain of 32 square root cells produces one root
// bit per cell, a register stage forms numerators and divisor, and two
// chains of long division cells, one quotient bit per cell, run side by
// side before a final output register saturates and packs the result.
// Throughput is one equation per cycle; the receiver cannot stall, so
// nothing is ever held back. Reset clears every valid flag in the pipeline,
// so no result is produced for transactions in flight at reset.
module quadratic_root_solver
#(
    parameter int COEF_FRAC_BITS = qrs_pkg::COEF_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  qrs_pkg::request_t   request,
    output logic                done,
    output qrs_pkg::result_t    result
);

    localparam int NW   = qrs_pkg::NUM_W + COEF_FRAC_BITS;
    localparam int NSQ  = qrs_pkg::ROOT_W;

    // Multiply stage.
    logic                      va_reg;
    logic signed [63:0]        bb_reg;
    logic signed [63:0]        ac_reg;
    logic signed [31:0]        a_reg;
    logic signed [31:0]        b_reg;
    logic signed [31:0]        c_reg;
    logic [3:0]                deg_reg;
    logic signed [63:0]        bb_next;
    logic signed [63:0]        ac_next;

    // Discriminant stage.
    logic                      vb_reg;
    qrs_pkg::root_side_t       sb_reg;
    qrs_pkg::root_side_t       sb_next;
    logic signed [63:0]        u;
    logic                      dsat_hi;
    logic                      dsat_lo;
    logic signed [63:0]        disc_q;

    // Square root chain.
    logic [qrs_pkg::SREM_W-1:0] sq_rem [0:NSQ];
    logic [qrs_pkg::ROOT_W-1:0] sq_root [0:NSQ];
    logic [qrs_pkg::RAD_W-1:0]  sq_rad [0:NSQ];
    qrs_pkg::root_side_t        rs_reg [0:NSQ-1];
    logic [NSQ-1:0]             vs_reg;

    // Numerator and divisor stage.
    logic                       vc_reg;
    logic [NW-1:0]              dq1_reg;
    logic [NW-1:0]              dq2_reg;
    logic [qrs_pkg::DVS_W-1:0]  dvs_reg;
    qrs_pkg::div_side_t         sc_reg;
    logic [NW-1:0]              dq1_next;
    logic [NW-1:0]              dq2_next;
    logic [qrs_pkg::DVS_W-1:0]  dvs_next;
    qrs_pkg::div_side_t         sc_next;
    qrs_pkg::root_side_t        rs_last;
    logic                       lin;
    logic signed [33:0]         num1;
    logic signed [33:0]         num2;
    logic signed [32:0]         den;
    logic [33:0]                mag1;
    logic [33:0]                mag2;
    logic [32:0]                dmag;

    // Divider chains.
    logic [qrs_pkg::DVS_W-1:0]  d1_rem [0:NW];
    logic [NW-1:0]              d1_dq [0:NW];
    logic [qrs_pkg::DVS_W-1:0]  d1_dvs [0:NW];
    logic [qrs_pkg::DVS_W-1:0]  d2_rem [0:NW];
    logic [NW-1:0]              d2_dq [0:NW];
    logic [qrs_pkg::DVS_W-1:0]  d2_dvs [0:NW];
    qrs_pkg::div_side_t         ds_reg [0:NW-1];
    logic [NW-1:0]              vd_reg;

    // Output stage.
    logic                       done_reg;
    qrs_pkg::result_t           res_reg;
    qrs_pkg::result_t           res_next;
    qrs_pkg::div_side_t         ds_last;
    logic [32:0]                sat1;
    logic [32:0]                sat2;

    // Returns {overflow, value} for a quotient magnitude and its sign.
    function automatic logic [32:0] sat_root(input logic [NW-1:0] q, input logic neg);
        logic [NW-32:0] hi;
        logic           ovf;
        logic [31:0]    val;
        hi = q[NW-1:31];
        if (neg)
        begin
            ovf = (hi > 1) || ((hi == 1) && (q[30:0] != 31'd0));
            val = ovf ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end
        else
        begin
            ovf = (hi != 0);
            val = ovf ? 32'h7FFF_FFFF : q[31:0];
        end
        return {ovf, val};
    endfunction

    assign busy = 1'b0;

    always_comb
    begin
        bb_next = 64'(request.coef_lin) * 64'(request.coef_lin);
        ac_next = 64'(request.coef_sq) * 64'(request.coef_const);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        bb_reg  <= bb_next;
        ac_reg  <= ac_next;
        a_reg   <= request.coef_sq;
        b_reg   <= request.coef_lin;
        c_reg   <= request.coef_const;
        deg_reg <= request.poly_degree;
    end

    // b*b - 4ac is formed as 4*((b*b >> 2) - ac) + (b*b mod 4) to stay in range.
    always_comb
    begin
        u       = (bb_reg >>> 2) - ac_reg;
        dsat_hi = !u[63] && (u[62:61] != 2'b00);
        dsat_lo = u[63] && (u[62:61] != 2'b11);
        priority if (dsat_hi)
        begin
            disc_q = 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        else if (dsat_lo)
        begin
            disc_q = 64'sh8000_0000_0000_0000;
        end
        else
        begin
            disc_q = {u[61:0], bb_reg[1:0]};
        end

        sb_next.a    = a_reg;
        sb_next.b    = b_reg;
        sb_next.c    = c_reg;
        sb_next.disc = disc_q;
        priority if (deg_reg > 4'd2)
        begin
            sb_next.mode = qrs_pkg::MODE_HIGH;
            sb_next.disc = '0;
        end
        else if (deg_reg < 4'd2)
        begin
            sb_next.mode = (b_reg == 32'sd0) ? qrs_pkg::MODE_LIN0 : qrs_pkg::MODE_LIN;
            sb_next.disc = '0;
        end
        else if (a_reg == 32'sd0)
        begin
            sb_next.mode = qrs_pkg::MODE_QDIV0;
        end
        else if (dsat_hi || dsat_lo)
        begin
            sb_next.mode = qrs_pkg::MODE_QSAT;
        end
        else if (disc_q < 64'sd0)
        begin
            sb_next.mode = qrs_pkg::MODE_QNONE;
        end
        else if (disc_q == 64'sd0)
        begin
            sb_next.mode = qrs_pkg::MODE_QDBL;
        end
        else
        begin
            sb_next.mode = qrs_pkg::MODE_QTWO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            vs_reg <= '0;
            vc_reg <= 1'b0;
            vd_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vb_reg   <= va_reg;
            vs_reg   <= {vs_reg[NSQ-2:0], vb_reg};
            vc_reg   <= vs_reg[NSQ-1];
            vd_reg   <= {vd_reg[NW-2:0], vc_reg};
            done_reg <= vd_reg[NW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sb_reg <= sb_next;
    end

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = sb_reg.disc;

    genvar k;
    generate
        for (k = 0; k < NSQ; k++)
        begin : g_sqrt
            qrs_sqrt_cell u_cell
            (
                .clk    (clk),
                .rem_i  (sq_rem[k]),
                .root_i (sq_root[k]),
                .rad_i  (sq_rad[k]),
                .rem_o  (sq_rem[k+1]),
                .root_o (sq_root[k+1]),
                .rad_o  (sq_rad[k+1])
            );

            always_ff @(posedge clk)
            begin
                if (k == 0)
                begin
                    rs_reg[k] <= sb_reg;
                end
                else
                begin
                    rs_reg[k] <= rs_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    // A zero discriminant gives a zero root, so both roots fall to -b/2a.
    always_comb
    begin
        rs_last = rs_reg[NSQ-1];
        lin     = (rs_last.mode == qrs_pkg::MODE_LIN);
        if (lin)
        begin
            num1 = -34'(rs_last.c);
            den  = 33'(rs_last.b);
        end
        else
        begin
            num1 = -34'(rs_last.b) - $signed({2'b00, sq_root[NSQ]});
            den  = {rs_last.a, 1'b0};
        end
        num2 = -34'(rs_last.b) + $signed({2'b00, sq_root[NSQ]});
        mag1 = num1[33] ? 34'(-num1) : 34'(num1);
        mag2 = num2[33] ? 34'(-num2) : 34'(num2);
        dmag = den[32] ? 33'(-den) : 33'(den);

        dq1_next = NW'(mag1[qrs_pkg::NUM_W-1:0]) << COEF_FRAC_BITS;
        dq2_next = NW'(mag2[qrs_pkg::NUM_W-1:0]) << COEF_FRAC_BITS;
        dvs_next = dmag;

        sc_next.mode = rs_last.mode;
        sc_next.disc = rs_last.disc;
        sc_next.neg1 = num1[33] ^ den[32];
        sc_next.neg2 = num2[33] ^ den[32];
    end

    always_ff @(posedge clk)
    begin
        dq1_reg <= dq1_next;
        dq2_reg <= dq2_next;
        dvs_reg <= dvs_next;
        sc_reg  <= sc_next;
    end

    assign d1_rem[0] = '0;
    assign d1_dq[0]  = dq1_reg;
    assign d1_dvs[0] = dvs_reg;
    assign d2_rem[0] = '0;
    assign d2_dq[0]  = dq2_reg;
    assign d2_dvs[0] = dvs_reg;

    generate
        for (k = 0; k < NW; k++)
        begin : g_div
            qrs_div_cell #(.NW(NW)) u_low
            (
                .clk   (clk),
                .rem_i (d1_rem[k]),
                .dq_i  (d1_dq[k]),
                .dvs_i (d1_dvs[k]),
                .rem_o (d1_rem[k+1]),
                .dq_o  (d1_dq[k+1]),
                .dvs_o (d1_dvs[k+1])
            );

            qrs_div_cell #(.NW(NW)) u_high
            (
                .clk   (clk),
                .rem_i (d2_rem[k]),
                .dq_i  (d2_dq[k]),
                .dvs_i (d2_dvs[k]),
                .rem_o (d2_rem[k+1]),
                .dq_o  (d2_dq[k+1]),
                .dvs_o (d2_dvs[k+1])
            );

            always_ff @(posedge clk)
            begin
                if (k == 0)
                begin
                    ds_reg[k] <= sc_reg;
                end
                else
                begin
                    ds_reg[k] <= ds_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    always_comb
    begin
        ds_last = ds_reg[NW-1];
        sat1    = sat_root(d1_dq[NW], ds_last.neg1);
        sat2    = sat_root(d2_dq[NW], ds_last.neg2);

        res_next.discriminant = ds_last.disc;
        res_next.root_low     = '0;
        res_next.root_high    = '0;
        unique case (ds_last.mode)
            qrs_pkg::MODE_HIGH:
            begin
                res_next.status = qrs_pkg::ST_HIGH_DEG;
            end
            qrs_pkg::MODE_LIN0, qrs_pkg::MODE_QDIV0:
            begin
                res_next.status = qrs_pkg::ST_DIV_ZERO;
            end
            qrs_pkg::MODE_LIN:
            begin
                res_next.root_low = sat1[31:0];
                res_next.status   = sat1[32] ? qrs_pkg::ST_SAT : qrs_pkg::ST_LINEAR;
            end
            qrs_pkg::MODE_QSAT:
            begin
                res_next.status = qrs_pkg::ST_SAT;
            end
            qrs_pkg::MODE_QNONE:
            begin
                res_next.status = qrs_pkg::ST_NONE;
            end
            qrs_pkg::MODE_QDBL:
            begin
                res_next.root_low  = sat1[31:0];
                res_next.root_high = sat2[31:0];
                res_next.status    = (sat1[32] || sat2[32]) ? qrs_pkg::ST_SAT
                                                             : qrs_pkg::ST_DOUBLE;
            end
            default:
            begin
                res_next.root_low  = sat1[31:0];
                res_next.root_high = sat2[31:0];
                res_next.status    = (sat1[32] || sat2[32]) ? qrs_pkg::ST_SAT
                                                             : qrs_pkg::ST_TWO;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== bench/qrs_checker.sv =====
`timescale 1ns / 1ps
module qrs_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  qrs_pkg::request_t request,
    input  logic              done,
    input  qrs_pkg::result_t  result,
    output int                fail_count,
    output int                pending
);

    localparam int FRAC = qrs_pkg::COEF_FRAC_BITS_DEF;

    qrs_pkg::result_t solutions_due[$];

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] bitv;
        r = 0;
        rem = v;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= r + bitv)
            begin
                rem = rem - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Quotient truncated toward zero, saturated to 32 bits.
    function automatic logic signed [31:0] fixed_quot(input logic signed [127:0] num,
                                                      input logic signed [127:0] den,
                                                      inout logic clipped);
        logic signed [127:0] q;
        q = (num <<< FRAC) / den;
        if (q > 128'sd2147483647)
        begin
            clipped = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -128'sd2147483648)
        begin
            clipped = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    function automatic qrs_pkg::result_t solve_equation(input qrs_pkg::request_t q);
        qrs_pkg::result_t r;
        logic signed [127:0] a, b, c, u, bb, s;
        logic clipped;
        r = '0;
        clipped = 1'b0;
        a = 128'(q.coef_sq);
        b = 128'(q.coef_lin);
        c = 128'(q.coef_const);
        if (q.poly_degree > 2)
            r.status = qrs_pkg::ST_HIGH_DEG;
        else if (q.poly_degree < 2)
        begin
            if (b == 0)
                r.status = qrs_pkg::ST_DIV_ZERO;
            else
            begin
                r.root_low = fixed_quot(-c, b, clipped);
                r.status = clipped ? qrs_pkg::ST_SAT : qrs_pkg::ST_LINEAR;
            end
        end
        else
        begin
            bb = b * b;
            u = (bb >>> 2) - a * c;
            if (u >= (128'sd1 <<< 61))
                r.discriminant = 64'sh7fffffffffffffff;
            else if (u < -(128'sd1 <<< 61))
                r.discriminant = 64'sh8000000000000000;
            else
                r.discriminant = 64'(u * 4 + (bb & 3));
            if (a == 0)
                r.status = qrs_pkg::ST_DIV_ZERO;
            else if (u >= (128'sd1 <<< 61) || u < -(128'sd1 <<< 61))
                r.status = qrs_pkg::ST_SAT;
            else if (r.discriminant < 0)
                r.status = qrs_pkg::ST_NONE;
            else if (r.discriminant == 0)
            begin
                r.root_low = fixed_quot(-b, 2 * a, clipped);
                r.root_high = r.root_low;
                r.status = clipped ? qrs_pkg::ST_SAT : qrs_pkg::ST_DOUBLE;
            end
            else
            begin
                s = {64'd0, floor_sqrt(r.discriminant)};
                r.root_low = fixed_quot(-b - s, 2 * a, clipped);
                r.root_high = fixed_quot(-b + s, 2 * a, clipped);
                r.status = clipped ? qrs_pkg::ST_SAT : qrs_pkg::ST_TWO;
            end
        end
        return r;
    endfunction

    assign pending = solutions_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        qrs_pkg::result_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            solutions_due.delete();
        end
        else
        begin
            if (done)
            begin
                if (solutions_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result %h", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = solutions_due.pop_front();
                    if (result.discriminant !== want.discriminant
                        || result.root_low !== want.root_low
                        || result.root_high !== want.root_high
                        || result.status !== want.status)
                    begin
                        if (fail_count < 10)
                            $display("Mismatch: disc %h/%h low %h/%h high %h/%h st %0d/%0d",
                                     want.discriminant, result.discriminant,
                                     want.root_low, result.root_low,
                                     want.root_high, result.root_high,
                                     want.status, result.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                solutions_due.push_back(solve_equation(request));
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int LATENCY = 85;
    localparam int CYCLE_LIMIT = 200000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    qrs_pkg::request_t request;
    logic              done;
    qrs_pkg::result_t  result;
    int                fail_count;
    int                pending;
    int                cycles;

    quadratic_root_solver dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .done(done), .result(result)
    );

    qrs_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            3: return 32'($urandom_range(0, 8)) << 16;
            4: return 32'h80000000 | 32'($urandom_range(0, 3));
            default: return 32'h7fffffff - 32'($urandom_range(0, 3));
        endcase
    endfunction

    // Hold off until the transaction is taken; a gap lowers start on the way.
    task automatic issue(input qrs_pkg::request_t q);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 1) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        request <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic issue_eq(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic [3:0] d);
        qrs_pkg::request_t q;
        q.coef_sq = a;
        q.coef_lin = b;
        q.coef_const = c;
        q.poly_degree = d;
        issue(q);
    endtask

    initial
    begin
        qrs_pkg::request_t q;
        cycles = 0;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Two roots, double root, no real root, linear and degree too high.
        issue_eq(32'h10000, 32'hfffd0000, 32'h20000, 4'd2);
        issue_eq(32'h10000, 32'hfffe0000, 32'h10000, 4'd2);
        issue_eq(32'h10000, 32'h0, 32'h10000, 4'd2);
        issue_eq(32'h0, 32'h20000, 32'h40000, 4'd1);
        issue_eq(32'h0, 32'h20000, 32'h40000, 4'd0);
        issue_eq(32'h10000, 32'h10000, 32'h10000, 4'd15);
        issue_eq(32'h10000, 32'h10000, 32'h10000, 4'd3);
        // Zero divisors on both paths.
        issue_eq(32'h0, 32'h10000, 32'h10000, 4'd2);
        issue_eq(32'h12345, 32'h0, 32'h10000, 4'd1);
        // Discriminant saturation at both ends, and root saturation.
        issue_eq(32'h80000000, 32'h80000000, 32'h7fffffff, 4'd2);
        issue_eq(32'h7fffffff, 32'h0, 32'h7fffffff, 4'd2);
        issue_eq(32'h80000000, 32'h80000000, 32'h80000000, 4'd2);
        issue_eq(32'h1, 32'h7fffffff, 32'h0, 4'd2);
        issue_eq(32'h0, 32'h1, 32'h7fffffff, 4'd1);
        issue_eq(32'h0, 32'hffffffff, 32'h80000000, 4'd0);
        issue_eq(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 4'd1);
        issue_eq(32'h1, 32'h2, 32'h1, 4'd2);
        issue_eq(32'hffffffff, 32'hffffffff, 32'hffffffff, 4'd2);

        // Let the pipeline drain before the random part.
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        for (int n = 0; n < 1400; n++)
        begin
            q.coef_sq = pick_coef();
            q.coef_lin = pick_coef();
            q.coef_const = pick_coef();
            if ($urandom_range(0, 7) == 0)
                q.poly_degree = 4'($urandom_range(0, 15));
            else
                q.poly_degree = 4'($urandom_range(0, 9) < 7 ? 2 : $urandom_range(0, 1));
            issue(q);
            if (n == 700)
            begin
                start <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
bench/qrs_checker.sv
bench/tb_top.sv
